// ----- hdl/seven_segment_scan_multiplexer_core_defines.svh -----
// Assertion macros for the seven-segment scan multiplexer.
// Included by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_SCAN_MULTIPLEXER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_MULTIPLEXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SSSM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SSSM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sssm_pkg.sv -----
// Shared types, constants and segment tables for the scan multiplexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sssm_pkg;

    // Input transaction payload.
    typedef struct packed {
        logic [13:0] speed_value;
        logic [18:0] time_seconds;
        logic        time_unset;
        logic        running;
        logic        knob_active;
        logic        speed_blink_off;
        logic        time_blink_off;
        logic        colon_blink_off;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [3:0] scan_slot;
        logic [6:0] segments;
        logic [9:0] digit_enable;
    } t_out_item;

    // Display flags carried alongside the decoded digits.
    typedef struct packed {
        logic time_unset;
        logic running;
        logic speed_off;
        logic time_off;
        logic colon_off;
    } t_flags;

    // Decoded digits handed from the digit pipeline to the scan stage.
    typedef struct packed {
        logic [3:0] sp_thou;
        logic [3:0] sp_hund;
        logic [3:0] sp_tens;
        logic       sp_ge1000;
        logic       sp_ge100;
        logic       sp_ge10;
        logic [3:0] hr_tens;
        logic [3:0] hr_units;
        logic [3:0] mn_tens;
        logic [3:0] mn_units;
        t_flags     flags;
    } t_digits;

    localparam logic [13:0] SPEED_MAX      = 14'd9999;
    localparam logic [18:0] TIME_MAX       = 19'd359999;
    localparam logic [7:0]  SPIN_DIV_RESET = 8'd10;

    // Scan slots.
    localparam logic [3:0] SLOT_SPD_1000 = 4'd1;
    localparam logic [3:0] SLOT_SPD_100  = 4'd2;
    localparam logic [3:0] SLOT_SPD_10   = 4'd3;
    localparam logic [3:0] SLOT_SPD_1    = 4'd4;
    localparam logic [3:0] SLOT_HR_TENS  = 4'd5;
    localparam logic [3:0] SLOT_HR_UNITS = 4'd6;
    localparam logic [3:0] SLOT_MN_TENS  = 4'd7;
    localparam logic [3:0] SLOT_MN_UNITS = 4'd8;
    localparam logic [3:0] SLOT_COLON    = 4'd9;
    localparam logic [3:0] SLOT_SPIN     = 4'd10;
    localparam logic [3:0] SLOT_BLANK    = 4'd11;
    localparam logic [3:0] SLOT_NONE     = 4'd0;

    // Segment patterns, A in bit 6 down to G in bit 0.
    localparam logic [6:0] SEG_DASH  = 7'h01;
    localparam logic [6:0] SEG_COLON = 7'h0C;
    localparam logic [6:0] SEG_RING  = 7'h7E;
    localparam logic [6:0] SEG_ZERO  = 7'h7E;

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h7E;
            4'd1:    s = 7'h30;
            4'd2:    s = 7'h6D;
            4'd3:    s = 7'h79;
            4'd4:    s = 7'h33;
            4'd5:    s = 7'h5B;
            4'd6:    s = 7'h5F;
            4'd7:    s = 7'h70;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7B;
            default: s = 7'h7E;
        endcase
        return s;
    endfunction

    // Spinner frames 1..3; frame 0 never shows but maps like frame 1.
    function automatic logic [6:0] spin_seg(input logic [1:0] f);
        logic [6:0] s;
        unique case (f)
            2'd2:    s = 7'h6C;
            2'd3:    s = 7'h36;
            default: s = 7'h5A;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/sssm_digit_pipe.sv -----
// Digit extraction pipeline: input register plus three decode stages.
// Depends on sssm_pkg for payload and digit types.
`timescale 1ns / 1ps

module sssm_digit_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sssm_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_take,
    output sssm_pkg::t_digits  o_digits
);
    import sssm_pkg::*;

    // Reciprocals: hours = (secs/16)*HR_RECIP >> 23, speed/10 = speed*Q10_RECIP >> 19,
    // rem/60 = (rem/4)*MN_RECIP >> 15, rem/600 = (rem/8)*MT_RECIP >> 16.
    localparam logic [15:0] HR_RECIP  = 16'd37283;
    localparam logic [15:0] Q10_RECIP = 16'd52429;
    localparam logic [11:0] MN_RECIP  = 12'd2185;
    localparam logic [9:0]  MT_RECIP  = 10'd874;

    typedef struct packed {
        logic [9:0]  q10;
        logic [6:0]  hours;
        logic [18:0] secs;
        t_flags      flags;
    } t_stage1;

    typedef struct packed {
        logic [6:0]  q100;
        logic [3:0]  sp_tens;
        logic        sp_ge10;
        logic [11:0] rem;
        logic [3:0]  hr_tens;
        logic [3:0]  hr_units;
        t_flags      flags;
    } t_stage2;

    // Exact x/10 for x up to 1028.
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [20:0] p;
        p = {11'd0, x} * 21'd205;
        return p[17:11];
    endfunction

    t_in_item r_s0;
    t_stage1  r_s1;
    t_stage2  r_s2;
    t_digits  r_s3;
    logic     r_v0, r_v1, r_v2, r_v3;
    logic     rdy1, rdy2, rdy3;

    // Stage 1: saturate, hours and speed/10.
    logic [13:0] s1_speed;
    logic [18:0] s1_secs;
    logic [30:0] s1_hr_prod;
    logic [29:0] s1_q10_prod;
    t_stage1     n_s1;

    always_comb begin
        s1_speed    = (r_s0.speed_value > SPEED_MAX) ? SPEED_MAX : r_s0.speed_value;
        s1_secs     = (r_s0.time_seconds > TIME_MAX) ? TIME_MAX : r_s0.time_seconds;
        s1_hr_prod  = {16'd0, s1_secs[18:4]} * {15'd0, HR_RECIP};
        s1_q10_prod = {16'd0, s1_speed} * {14'd0, Q10_RECIP};
        n_s1.q10    = s1_q10_prod[28:19];
        n_s1.hours  = s1_hr_prod[29:23];
        n_s1.secs   = s1_secs;
        n_s1.flags.time_unset = r_s0.time_unset;
        n_s1.flags.running    = r_s0.running;
        n_s1.flags.speed_off  = r_s0.speed_blink_off & ~r_s0.knob_active;
        n_s1.flags.time_off   = r_s0.time_blink_off & ~r_s0.knob_active;
        n_s1.flags.colon_off  = r_s0.colon_blink_off;
    end

    // Stage 2: speed/100, tens digit, hour digits, seconds left over after the hours.
    logic [6:0]  s2_q100;
    logic [9:0]  s2_q100x10;
    logic [9:0]  s2_tens10;
    logic [18:0] s2_hr_secs;
    logic [18:0] s2_rem19;
    logic [6:0]  s2_hr_t7;
    logic [6:0]  s2_hr_tx10;
    logic [6:0]  s2_hr_u7;
    t_stage2     n_s2;

    always_comb begin
        s2_q100    = div10(r_s1.q10);
        s2_q100x10 = ({3'd0, s2_q100} << 3) + ({3'd0, s2_q100} << 1);
        s2_tens10  = r_s1.q10 - s2_q100x10;
        s2_hr_secs = {12'd0, r_s1.hours} * 19'd3600;
        s2_rem19   = r_s1.secs - s2_hr_secs;
        s2_hr_t7   = div10({3'd0, r_s1.hours});
        s2_hr_tx10 = (s2_hr_t7 << 3) + (s2_hr_t7 << 1);
        s2_hr_u7   = r_s1.hours - s2_hr_tx10;
        n_s2.q100     = s2_q100;
        n_s2.sp_tens  = s2_tens10[3:0];
        n_s2.sp_ge10  = (r_s1.q10 != 10'd0);
        n_s2.rem      = s2_rem19[11:0];
        n_s2.hr_tens  = s2_hr_t7[3:0];
        n_s2.hr_units = s2_hr_u7[3:0];
        n_s2.flags    = r_s1.flags;
    end

    // Stage 3: thousands and hundreds, minute digits.
    logic [6:0]  s3_q1000;
    logic [6:0]  s3_q1000x10;
    logic [6:0]  s3_hund7;
    logic [21:0] s3_mn_prod;
    logic [18:0] s3_mt_prod;
    logic [5:0]  s3_mins;
    logic [5:0]  s3_mt6;
    logic [5:0]  s3_mtx10;
    logic [5:0]  s3_mu6;
    t_digits     n_s3;

    always_comb begin
        s3_q1000    = div10({3'd0, r_s2.q100});
        s3_q1000x10 = (s3_q1000 << 3) + (s3_q1000 << 1);
        s3_hund7    = r_s2.q100 - s3_q1000x10;
        s3_mn_prod  = {12'd0, r_s2.rem[11:2]} * {10'd0, MN_RECIP};
        s3_mt_prod  = {10'd0, r_s2.rem[11:3]} * {9'd0, MT_RECIP};
        s3_mins     = s3_mn_prod[20:15];
        s3_mt6      = {3'd0, s3_mt_prod[18:16]};
        s3_mtx10    = (s3_mt6 << 3) + (s3_mt6 << 1);
        s3_mu6      = s3_mins - s3_mtx10;
        n_s3.sp_thou   = s3_q1000[3:0];
        n_s3.sp_hund   = s3_hund7[3:0];
        n_s3.sp_tens   = r_s2.sp_tens;
        n_s3.sp_ge1000 = (s3_q1000 != 7'd0);
        n_s3.sp_ge100  = (r_s2.q100 != 7'd0);
        n_s3.sp_ge10   = r_s2.sp_ge10;
        n_s3.hr_tens   = r_s2.hr_tens;
        n_s3.hr_units  = r_s2.hr_units;
        n_s3.mn_tens   = s3_mt6[3:0];
        n_s3.mn_units  = s3_mu6[3:0];
        n_s3.flags     = r_s2.flags;
    end

    // A stage loads when it is empty or its contents move on.
    assign rdy3    = ~r_v3 | i_take;
    assign rdy2    = ~r_v2 | rdy3;
    assign rdy1    = ~r_v1 | rdy2;
    assign o_ready = ~r_v0 | rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            if (rdy1)    r_v1 <= r_v0;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_s0 <= i_item;
        if (rdy1 && r_v0)       r_s1 <= n_s1;
        if (rdy2 && r_v1)       r_s2 <= n_s2;
        if (rdy3 && r_v2)       r_s3 <= n_s3;
    end

    assign o_valid  = r_v3;
    assign o_digits = r_s3;

endmodule

// ----- hdl/sssm_scan_ctrl.sv -----
// Scan stage: slot counter, spinner animation and the result register.
// Depends on sssm_pkg for digit, output types and segment tables.
`timescale 1ns / 1ps

module sssm_scan_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_spin_divider,
    input  logic                i_valid,
    input  sssm_pkg::t_digits   i_digits,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sssm_pkg::t_out_item o_out_item
);
    import sssm_pkg::*;

    logic [3:0] r_slot_cnt;
    logic [7:0] r_tick_cnt;
    logic [1:0] r_frame;
    logic [6:0] r_pattern;
    logic [6:0] r_held;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic [3:0] n_slot;
    logic [3:0] n_slot_cnt;
    logic [7:0] n_tick;
    logic [7:0] tick_inc;
    logic [1:0] n_frame;
    logic [6:0] n_pattern;
    logic [6:0] n_held;
    logic [9:0] n_en;
    logic [3:0] time_dig;
    t_flags     fl;

    assign fl     = i_digits.flags;
    assign o_take = i_valid & (~r_out_valid | i_out_ready);

    always_comb begin
        n_slot    = (r_slot_cnt >= SLOT_SPIN) ? SLOT_BLANK : r_slot_cnt + 4'd1;
        n_held    = r_held;
        n_en      = '0;
        n_tick    = r_tick_cnt;
        n_frame   = r_frame;
        n_pattern = r_pattern;
        tick_inc  = r_tick_cnt + 8'd1;
        time_dig  = i_digits.hr_tens;

        unique case (n_slot)
            SLOT_SPD_1000: begin
                if (i_digits.sp_ge1000) begin
                    n_held  = digit_seg(i_digits.sp_thou);
                    n_en[0] = ~fl.speed_off;
                end
            end
            SLOT_SPD_100: begin
                if (i_digits.sp_ge100) begin
                    n_held  = digit_seg(i_digits.sp_hund);
                    n_en[1] = ~fl.speed_off;
                end
            end
            SLOT_SPD_10: begin
                if (i_digits.sp_ge10) begin
                    n_held  = digit_seg(i_digits.sp_tens);
                    n_en[2] = ~fl.speed_off;
                end
            end
            SLOT_SPD_1: begin
                n_held  = SEG_ZERO;
                n_en[3] = ~fl.speed_off;
            end
            SLOT_HR_TENS, SLOT_HR_UNITS, SLOT_MN_TENS, SLOT_MN_UNITS: begin
                unique case (n_slot)
                    SLOT_HR_TENS:  time_dig = i_digits.hr_tens;
                    SLOT_HR_UNITS: time_dig = i_digits.hr_units;
                    SLOT_MN_TENS:  time_dig = i_digits.mn_tens;
                    default:       time_dig = i_digits.mn_units;
                endcase
                n_held = fl.time_unset ? SEG_DASH : digit_seg(time_dig);
                n_en[n_slot - 4'd1] = ~fl.time_off;
            end
            SLOT_COLON: begin
                n_held  = SEG_COLON;
                n_en[8] = ~(fl.colon_off & fl.running & fl.time_unset);
            end
            SLOT_SPIN: begin
                // Step the frame once the tick count reaches the divider.
                if (tick_inc >= i_spin_divider) begin
                    n_tick    = '0;
                    n_frame   = (r_frame >= 2'd3) ? 2'd1 : r_frame + 2'd1;
                    n_pattern = spin_seg(n_frame);
                end else begin
                    n_tick = tick_inc;
                end
                if (!fl.running) n_pattern = SEG_RING;
                n_held  = n_pattern;
                n_en[9] = 1'b1;
            end
            default: begin
                // Blanking slot: drive nothing, keep the segment lines.
            end
        endcase

        n_slot_cnt = (n_slot == SLOT_BLANK) ? SLOT_NONE : n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt  <= SLOT_NONE;
            r_tick_cnt  <= '0;
            r_frame     <= '0;
            r_pattern   <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_slot_cnt  <= n_slot_cnt;
                r_tick_cnt  <= n_tick;
                r_frame     <= n_frame;
                r_pattern   <= n_pattern;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_item.scan_slot    <= n_slot;
            r_out_item.segments     <= n_held;
            r_out_item.digit_enable <= n_en;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/seven_segment_scan_multiplexer_core.sv -----
// Top level of the seven-segment scan multiplexer.
// Depends on sssm_pkg, sssm_digit_pipe, sssm_scan_ctrl and the defines header.
`timescale 1ns / 1ps
`include "seven_segment_scan_multiplexer_core_defines.svh"

// Usage:
// Each input transaction is one scan tick carrying speed, time in seconds and
// the display flags. Each tick yields exactly one output transaction: the slot
// just driven (1..11), the segment pattern and a position enable with at most one bit set.
// Input and output channels use valid/ready; the configuration channel writes
// the spinner divider (reset value 10) and is always ready. Write it only
// while no tick is in flight.
// Each accepted tick passes the input register, three digit-decode stages,
// then the scan stage into the result register. Throughput: one tick per cycle
// while the receiver takes results; each stage holds one tick.
// Reset (synchronous, active low) empties the pipeline, returns the slot
// counter to zero, clears spinner state and held segments, and reloads the
// divider. When the receiver stalls, the result holds and the stages behind
// it keep filling; input ready drops only once every stage is occupied.
module seven_segment_scan_multiplexer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sssm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sssm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import sssm_pkg::*;

    logic      r_spin_divider;
    logic      dig_valid;
    logic      dig_take;
    t_digits   digits;
    logic [7:0] r_spin_div;

    // Hold the divider; accept a write on every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_div <= SPIN_DIV_RESET;
        end else if (i_cfg_valid) begin
            r_spin_div <= i_cfg_data;
        end
    end

    // Flag a divider write for the record; the flag is the registered write valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_divider <= 1'b0;
        end else begin
            r_spin_divider <= i_cfg_valid;
        end
    end

    // Split the numbers into digits, one stage per dependent step.
    sssm_digit_pipe u_digit_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_data),
        .o_valid  (dig_valid),
        .i_take   (dig_take),
        .o_digits (digits)
    );

    // Advance the slot, animate the spinner and register the result.
    sssm_scan_ctrl u_scan_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_spin_divider (r_spin_div),
        .i_valid        (dig_valid),
        .i_digits       (digits),
        .o_take         (dig_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_data)
    );

    // At most one position lit per result.
    `SSSM_ASSERT_IMP(a_enable_onehot, i_clk, i_rst_n, o_out_valid, $onehot0(o_out_data.digit_enable), "more than one position enabled")

    // Slot number stays in the scan range.
    `SSSM_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, o_out_valid, (o_out_data.scan_slot >= SLOT_SPD_1000) && (o_out_data.scan_slot <= SLOT_BLANK), "scan slot out of range")

    // The blanking slot lights nothing.
    `SSSM_ASSERT_IMP(a_blank_dark, i_clk, i_rst_n, o_out_valid && (o_out_data.scan_slot == SLOT_BLANK), o_out_data.digit_enable == 10'd0, "blanking slot enabled a position")

    // After the blanking slot leaves, the next result starts a new scan.
    `SSSM_ASSERT_NXT(a_wrap_first, i_clk, i_rst_n, o_out_valid && i_out_ready && (o_out_data.scan_slot == SLOT_BLANK) && !r_spin_divider, !o_out_valid || (o_out_data.scan_slot == SLOT_SPD_1000), "scan did not wrap to the first slot")

endmodule
